### src/utcd_pkg.sv
// Package for the UTC date converter.
// Holds the state encoding, field widths, divisors and calendar tables.
// No dependencies.
package utcd_pkg;

  // Field widths
  localparam int unsigned SecondsW = 32;
  localparam int unsigned DaysW    = 16;  // up to 49710 days in the 32-bit range
  localparam int unsigned RemW     = 18;  // partial remainder, below twice 86400
  localparam int unsigned YearW    = 12;
  localparam int unsigned YdayW    = 9;
  localparam int unsigned MonW     = 4;
  localparam int unsigned CntW     = 5;

  // Divisors
  localparam logic [RemW-1:0] SecsPerDay  = 18'd86400;
  localparam logic [RemW-1:0] SecsPerHour = 18'd3600;
  localparam logic [RemW-1:0] SecsPerMin  = 18'd60;
  localparam logic [RemW-1:0] DaysPerWeek = 18'd7;

  // Epoch facts
  localparam logic [YearW-1:0] FirstYear    = 12'd1970;
  localparam logic [DaysW-1:0] FirstWeekday = 16'd4;   // 1970-01-01 was a Thursday
  localparam logic [MonW-1:0]  LastMonIdx   = 4'd11;   // December, zero-based

  // Step counts of each restoring division, less one
  localparam logic [CntW-1:0] DayStepsM1  = 5'd31;
  localparam logic [CntW-1:0] HourStepsM1 = 5'd16;
  localparam logic [CntW-1:0] MinStepsM1  = 5'd11;
  localparam logic [CntW-1:0] WdayStepsM1 = 5'd15;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DAY  = 8'b0000_0010,
    S_HOUR = 8'b0000_0100,
    S_MIN  = 8'b0000_1000,
    S_WDAY = 8'b0001_0000,
    S_YEAR = 8'b0010_0000,
    S_MON  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } utcd_state_t;

  // Gregorian leap rule over 1970..2106: the only century in range that is
  // not a leap year is 2100 (2000 is one).
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic leap;
    leap = (y[1:0] == 2'b00) && (y != 12'd2100);
    return leap;
  endfunction

  function automatic logic [8:0] year_len(input logic [YearW-1:0] y);
    logic [8:0] len;
    len = 9'd365 + {8'd0, is_leap(y)};
    return len;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [MonW-1:0] idx);
    logic [4:0] len;
    unique case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### src/unix_seconds_to_utc_date_core.sv
// Unix seconds to broken-down UTC date converter, top level.
// Uses utcd_pkg for state encoding, divisors and calendar tables.
//
// Usage:
//   Input channel (in_valid / in_stall / in_seconds) takes one 32-bit count
//   of seconds since 1970-01-01 00:00:00 UTC per item. Result channel
//   (out_valid / out_stall / out_*) returns the second, minute, hour,
//   weekday (0 is Sunday), year, zero-based day of year, month (1..12) and
//   day of month for that item. One result per item, in order.
//   A single 18-bit compare-and-subtract unit does all the work under a
//   small sequencer: restoring divisions by 86400 (32 steps), 3600 (17),
//   60 (12) and 7 (16), then one subtraction per year past 1970 (plus the
//   final compare) and one per month. in_stall is high while an item is in
//   progress; the next item is taken once the previous one is done, even
//   while its result still waits in the output register.
//   When out_stall holds the result, out_valid and the fields stay put and
//   a finished item waits in the sequencer until the register frees up.
//   Synchronous active-low reset returns the sequencer to idle and drops
//   out_valid; no other state is kept between items.
module unix_seconds_to_utc_date_core
  import utcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [11:0] out_year,
  output logic [8:0]  out_year_day,
  output logic [3:0]  out_month,
  output logic [4:0]  out_month_day
);

  utcd_state_t         state_r, state_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [RemW-1:0]     acc_r, acc_nxt;
  logic [SecondsW-1:0] sh_r, sh_nxt;
  logic [DaysW-1:0]    days_r, days_nxt;
  logic [5:0]          sec_r, sec_nxt;
  logic [5:0]          min_r, min_nxt;
  logic [4:0]          hour_r, hour_nxt;
  logic [2:0]          wday_r, wday_nxt;
  logic [YearW-1:0]    year_r, year_nxt;
  logic [YdayW-1:0]    yday_r, yday_nxt;
  logic [MonW-1:0]     mon_r, mon_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  // Shared unit signals
  logic                div_mode;
  logic [RemW-1:0]     cand;
  logic [RemW-1:0]     operand;
  logic [RemW:0]       diff;
  logic                ge;
  logic [RemW-1:0]     step_rem;
  logic [SecondsW-1:0] step_q;
  logic [DaysW-1:0]    days_wk;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign days_wk   = days_r + FirstWeekday;

  // Select the operands of the shared compare-and-subtract unit
  assign div_mode = (state_r == S_DAY) || (state_r == S_HOUR) ||
                    (state_r == S_MIN) || (state_r == S_WDAY);
  assign cand     = div_mode ? {acc_r[RemW-2:0], sh_r[SecondsW-1]} : acc_r;

  always_comb begin
    priority case (1'b1)
      (state_r == S_DAY):  operand = SecsPerDay;
      (state_r == S_HOUR): operand = SecsPerHour;
      (state_r == S_MIN):  operand = SecsPerMin;
      (state_r == S_WDAY): operand = DaysPerWeek;
      (state_r == S_YEAR): operand = {9'd0, year_len(year_r)};
      default:             operand = {13'd0, month_len(is_leap(year_r), mon_r)};
    endcase
  end

  assign diff     = {1'b0, cand} - {1'b0, operand};
  assign ge       = !diff[RemW];
  assign step_rem = ge ? diff[RemW-1:0] : cand;
  assign step_q   = {sh_r[SecondsW-2:0], ge};

  // Sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    days_nxt  = days_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    year_nxt  = year_r;
    yday_nxt  = yday_r;
    mon_nxt   = mon_r;
    unique case (state_r)
      S_IDLE: begin
        // Take a new item and start the split into days
        if (in_valid) begin
          sh_nxt    = in_seconds;
          acc_nxt   = '0;
          cnt_nxt   = DayStepsM1;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        acc_nxt = step_rem;
        sh_nxt  = step_q;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          // Keep the day count, divide the time of day by 3600
          days_nxt  = step_q[DaysW-1:0];
          sh_nxt    = {step_rem[16:0], 15'd0};
          acc_nxt   = '0;
          cnt_nxt   = HourStepsM1;
          state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        acc_nxt = step_rem;
        sh_nxt  = step_q;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          hour_nxt  = step_q[4:0];
          sh_nxt    = {step_rem[11:0], 20'd0};
          acc_nxt   = '0;
          cnt_nxt   = MinStepsM1;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        acc_nxt = step_rem;
        sh_nxt  = step_q;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          // Minute and second done, reduce the shifted day count mod 7
          min_nxt   = step_q[5:0];
          sec_nxt   = step_rem[5:0];
          sh_nxt    = {days_wk, 16'd0};
          acc_nxt   = '0;
          cnt_nxt   = WdayStepsM1;
          state_nxt = S_WDAY;
        end
      end
      S_WDAY: begin
        acc_nxt = step_rem;
        sh_nxt  = step_q;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          wday_nxt  = step_rem[2:0];
          acc_nxt   = {2'd0, days_r};
          year_nxt  = FirstYear;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        // Peel off whole years until the remaining days fit in one
        if (ge) begin
          acc_nxt  = diff[RemW-1:0];
          year_nxt = year_r + 12'd1;
        end else begin
          yday_nxt  = acc_r[YdayW-1:0];
          mon_nxt   = '0;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        // Peel off whole months, capped at December
        if (ge && (mon_r != LastMonIdx)) begin
          acc_nxt = diff[RemW-1:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    days_r <= days_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    wday_r <= wday_nxt;
    year_r <= year_nxt;
    yday_r <= yday_nxt;
    mon_r  <= mon_nxt;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_second    <= sec_r;
      out_minute    <= min_r;
      out_hour      <= hour_r;
      out_weekday   <= wday_r;
      out_year      <= year_r;
      out_year_day  <= yday_r;
      out_month     <= mon_r + 4'd1;
      out_month_day <= acc_r[4:0] + 5'd1;
    end
  end

endmodule

### src/utcd_checker.sv
// Port-level checker for the UTC date converter.
// Depends on the ports of unix_seconds_to_utc_date_core; bound to it below.
module utcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_seconds,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_second,
  input logic [5:0]  out_minute,
  input logic [4:0]  out_hour,
  input logic [2:0]  out_weekday,
  input logic [11:0] out_year,
  input logic [8:0]  out_year_day,
  input logic [3:0]  out_month,
  input logic [4:0]  out_month_day
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year) && $stable(out_year_day) &&
      $stable(out_month_day) && $stable(out_second))
    else $error("stalled result item changed");

  // Hold an offered item until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_seconds))
    else $error("stalled input item changed");

  // Go busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("converter not busy after accepting an item");

  // Time of day and weekday stay in range
  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second < 6'd60) && (out_minute < 6'd60) &&
      (out_hour < 5'd24) && (out_weekday < 3'd7))
    else $error("time of day or weekday out of range");

  // Date fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) &&
      (out_month_day >= 5'd1) && (out_year >= 12'd1970) &&
      (out_year <= 12'd2106) && (out_year_day <= 9'd365))
    else $error("date field out of range");

endmodule

bind unix_seconds_to_utc_date_core utcd_checker u_utcd_checker (.*);

### dv/unix_seconds_to_utc_date_core_tb.sv
// Testbench for unix_seconds_to_utc_date_core: calendar extremes, leap days and random stamps
// checked against a local Gregorian date predictor, under random and long backpressure.
// Depends on utcd_pkg and the unix_seconds_to_utc_date_core RTL.
`timescale 1ns / 100ps

module unix_seconds_to_utc_date_core_tb
  import utcd_pkg::*;
();

  typedef struct packed {
    logic [5:0]       second;
    logic [5:0]       minute;
    logic [4:0]       hour;
    logic [2:0]       weekday;
    logic [YearW-1:0] year;
    logic [YdayW-1:0] year_day;
    logic [MonW-1:0]  month;
    logic [4:0]       month_day;
  } utc_date_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [31:0] in_seconds = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [11:0] out_year;
  logic [8:0]  out_year_day;
  logic [3:0]  out_month;
  logic [4:0]  out_month_day;

  utc_date_t   pending_dates[$];
  int unsigned stamps_sent    = 0;
  int unsigned dates_checked  = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;

  unix_seconds_to_utc_date_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_seconds   (in_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_second   (out_second),
    .out_minute   (out_minute),
    .out_hour     (out_hour),
    .out_weekday  (out_weekday),
    .out_year     (out_year),
    .out_year_day (out_year_day),
    .out_month    (out_month),
    .out_month_day(out_month_day)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Full Gregorian rule
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input bit leap, input int unsigned m);
    unique case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Seconds at midnight of a calendar date, not truncated
  function automatic longint epoch_of(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
    longint days;
    days = longint'(d) - 1;
    for (int unsigned yy = 1970; yy < y; yy++) days += leap_year(yy) ? 366 : 365;
    for (int unsigned mm = 1; mm < m; mm++) days += month_days(leap_year(y), mm);
    return days * 86400;
  endfunction

  // Break a stamp down into its UTC date
  function automatic utc_date_t predict_date(input logic [31:0] secs);
    utc_date_t   date;
    int unsigned tod;
    int unsigned days;
    int unsigned y;
    int unsigned m;
    bit          leap;
    tod  = secs % 86400;
    days = secs / 86400;
    date.second  = 6'(tod % 60);
    date.minute  = 6'((tod % 3600) / 60);
    date.hour    = 5'(tod / 3600);
    date.weekday = 3'((days + 4) % 7);
    y = 1970;
    while (days >= (leap_year(y) ? 366 : 365)) begin
      days -= leap_year(y) ? 366 : 365;
      y++;
    end
    date.year     = YearW'(y);
    date.year_day = YdayW'(days);
    leap = leap_year(y);
    m = 1;
    while (m < 12 && days >= month_days(leap, m)) begin
      days -= month_days(leap, m);
      m++;
    end
    date.month     = MonW'(m);
    date.month_day = 5'(days + 1);
    return date;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Record accepted items and compare each result with the oldest prediction
  always @(posedge clk) begin : scoreboard
    utc_date_t want;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        pending_dates.push_back(predict_date(in_seconds));
        stamps_sent++;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_dates.size() == 0) begin
          $error("result with no pending item: year %0d", out_year);
          mismatch_count++;
        end else begin
          want = pending_dates.pop_front();
          check_field("second", want.second, out_second);
          check_field("minute", want.minute, out_minute);
          check_field("hour", want.hour, out_hour);
          check_field("weekday", want.weekday, out_weekday);
          check_field("year", want.year, out_year);
          check_field("year_day", want.year_day, out_year_day);
          check_field("month", want.month, out_month);
          check_field("month_day", want.month_day, out_month_day);
          dates_checked++;
        end
      end
    end
  end

  // Drive the receiver stall: long hold-off when requested, else random
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold until accepted
  task automatic send_stamp(input logic [31:0] secs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_seconds = secs;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  // A mix of stamps anywhere, near month and year edges, or near the ends of the range
  function automatic logic [31:0] pick_random_stamp();
    int unsigned kind;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    longint      stamp;
    kind = $urandom_range(99);
    if (kind < 45) return $urandom;
    if (kind < 80) begin
      y = $urandom_range(2105, 1970);
      m = $urandom_range(12, 1);
      d = $urandom_range(1) ? 1 : month_days(leap_year(y), m);
      stamp = epoch_of(y, m, d) + longint'($urandom_range(172800)) - 86400;
      return 32'(stamp);
    end
    if (kind < 90) return $urandom_range(200000);
    return 32'hFFFF_FFFF - $urandom_range(200000);
  endfunction

  task automatic test_field_extremes();
    send_stamp(32'd0);
    send_stamp(32'd1);
    send_stamp(32'd59);
    send_stamp(32'd60);
    send_stamp(32'd3599);
    send_stamp(32'd3600);
    send_stamp(32'd86399);
    send_stamp(32'd86400);
    send_stamp(32'h7FFF_FFFF);
    send_stamp(32'h8000_0000);
    send_stamp(32'hFFFF_FFFE);
    send_stamp(32'hFFFF_FFFF);
  endtask

  // Leap days, last day of a leap year, the skipped leap day of 2100, final year
  task automatic test_calendar_edges();
    send_stamp(32'(epoch_of(1972, 2, 29)));
    send_stamp(32'(epoch_of(1972, 3, 1) - 1));
    send_stamp(32'(epoch_of(1972, 12, 31) + 86399));
    send_stamp(32'(epoch_of(1973, 1, 1)));
    send_stamp(32'(epoch_of(2000, 2, 29) + 43200));
    send_stamp(32'(epoch_of(2000, 12, 31)));
    send_stamp(32'(epoch_of(2100, 2, 28) + 86399));
    send_stamp(32'(epoch_of(2100, 3, 1)));
    send_stamp(32'(epoch_of(2104, 12, 31)));
    send_stamp(32'(epoch_of(2106, 1, 1)));
    send_stamp(32'(epoch_of(2106, 2, 7)));
    send_stamp(32'hAAAA_AAAA);
    send_stamp(32'h5555_5555);
    wait_drained();
  endtask

  task automatic test_random_stamps(input int unsigned count, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_stamp(pick_random_stamp());
    wait_drained();
  endtask

  // Hold the output for a long stretch while items keep coming, so the input stalls
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1500;
    repeat (16) send_stamp(pick_random_stamp());
    wait_drained();
  endtask

  // Pause the sender until everything is back, then resume
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (8) send_stamp(pick_random_stamp());
    wait_drained();
    repeat (8) send_stamp(pick_random_stamp());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_field_extremes();
    test_calendar_edges();
    test_random_stamps(370, 35, 48);
    test_random_stamps(370, 48, 35);
    test_random_stamps(370, 0, 0);
    test_output_hold();
    test_drain_pause();
    // let any stray result show up
    repeat (300) @(negedge clk);
    if (pending_dates.size() != 0) begin
      $error("%0d predicted dates never came back", pending_dates.size());
      mismatch_count++;
    end
    $display("Converted %0d stamps, %0d dates checked: range ends, leap days, year edges,",
             stamps_sent, dates_checked);
    $display("random stamps under three idle mixes, a long output hold and drain pauses.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    #(64'd20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
